>>> rtl/core/y2argb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and color math helpers for the YUV420SP to ARGB converter.
// No dependencies; the front end, back end and top level import this package.
package y2argb_pkg;

    localparam int COL_W      = 10;  // pixel column / frame width
    localparam int ROW_W      = 9;   // pixel row / frame height
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int TERM_W     = 10;  // truncated chroma terms
    localparam int PROD_W     = 25;  // coefficient times chroma offset
    localparam int ACC_W      = 26;  // Q14 green accumulator
    localparam int SUM_W      = 12;  // channel value before clamping

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 10'd320;
    localparam logic [ROW_W-1:0]      FRAME_HEIGHT_RST = 9'd240;

    // Q2.14 coefficients
    localparam logic signed [15:0] COEF_R  = 16'sd22458;
    localparam logic signed [15:0] COEF_G1 = 16'sd11436;
    localparam logic signed [15:0] COEF_G2 = 16'sd5532;
    localparam logic signed [15:0] COEF_B  = 16'sd28384;
    localparam int                 Q_FRAC  = 14;

    localparam logic signed [8:0] CHROMA_BIAS = 9'sd128;
    localparam logic [7:0]        ALPHA       = 8'hFF;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0] pixel_x;
        logic [ROW_W-1:0] pixel_y;
        logic [31:0]      argb_pixel;
        logic             last_of_block;
        logic             last_of_frame;
    } out_item_t;

    // one 2x2 block to convert
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       u;
        logic [7:0]       v;
        logic             frame_end;
    } job_t;

    typedef struct packed {
        logic q_full;
        logic idle;
    } back_status_t;

    // divide by 2^14, truncating toward zero
    function automatic logic signed [SUM_W-1:0] q14_trunc(input logic signed [ACC_W-1:0] val);
        logic signed [ACC_W-1:0] adj;
        adj = val + (val[ACC_W-1] ? ACC_W'((1 << Q_FRAC) - 1) : ACC_W'(0));
        return SUM_W'(adj >>> Q_FRAC);
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] val);
        logic [7:0] res;
        if (val < 0)
        begin
            res = 8'd0;
        end
        else if (val > SUM_W'(255))
        begin
            res = 8'd255;
        end
        else
        begin
            res = val[7:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/core/y2argb_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module y2argb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/y2argb_queue.sv
`timescale 1ns / 1ps
// Small register FIFO carrying block jobs from the front end to the back end.
// Depends on nothing but its parameters.
module y2argb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/y2argb_front.sv
`timescale 1ns / 1ps
// Front end: config registers, frame position tracking, luma store writes, job issue.
// Depends on y2argb_pkg.
module y2argb_front #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480,
    parameter int ADDR_W     = 19
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [y2argb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [y2argb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               byte_valid,
    output logic                               byte_ready,
    input  y2argb_pkg::in_item_t               byte_item,
    input  y2argb_pkg::back_status_t           back_status,
    output logic                               push,
    output y2argb_pkg::job_t                   push_job,
    output logic [ADDR_W-1:0]                  push_base,
    output logic                               ram_we,
    output logic [ADDR_W-1:0]                  ram_waddr,
    output logic [7:0]                         ram_wdata,
    output logic [y2argb_pkg::COL_W-1:0]       frame_w
);

    import y2argb_pkg::*;

    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT * 3 / 2 + 1);
    localparam int W_LIM = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;
    localparam int H_LIM = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam logic [COL_W-1:0] W_CAP = COL_W'(W_LIM);
    localparam logic [ROW_W-1:0] H_CAP = ROW_W'(H_LIM);

    typedef enum logic [2:0] {
        SYNC_DIMS,
        SYNC_SIZE,
        SYNC_TOTAL,
        SYNC_POS,
        SYNC_DIV,
        RUN
    } state_t;

    state_t              state_reg, state_next;
    logic [COL_W-1:0]    width_cfg_reg, width_cfg_next;
    logic [ROW_W-1:0]    height_cfg_reg, height_cfg_next;
    logic [COL_W-1:0]    w_reg, w_next;
    logic [ROW_W-1:0]    h_reg, h_next;
    logic [POS_W-1:0]    lsize_reg, lsize_next;
    logic [POS_W-1:0]    total_reg, total_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    rem_reg, rem_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [7:0]          held_u_reg, held_u_next;

    logic [COL_W-1:0]        w_clamp;
    logic [ROW_W-1:0]        h_clamp;
    logic [COL_W+ROW_W-1:0]  area;
    logic [POS_W-1:0]        diff;
    logic [POS_W-1:0]        p_eff;
    logic [POS_W-1:0]        p_inc;
    logic [COL_W-1:0]        col_eff;
    logic [ROW_W-1:0]        row_eff;
    logic [ADDR_W-1:0]       base_eff;
    logic                    is_luma;
    logic                    wrap;
    logic                    accept;

    always_comb
    begin
        if (width_cfg_reg < COL_W'(2))
        begin
            w_clamp = COL_W'(2);
        end
        else if (width_cfg_reg > W_CAP)
        begin
            w_clamp = W_CAP;
        end
        else
        begin
            w_clamp = width_cfg_reg;
        end
        if (height_cfg_reg < ROW_W'(2))
        begin
            h_clamp = ROW_W'(2);
        end
        else if (height_cfg_reg > H_CAP)
        begin
            h_clamp = H_CAP;
        end
        else
        begin
            h_clamp = height_cfg_reg;
        end
    end

    assign area = w_reg * h_reg;
    assign diff = pos_reg - lsize_reg;

    // frame_start restarts the position before the byte is used
    assign p_eff    = byte_item.frame_start ? '0 : pos_reg;
    assign col_eff  = byte_item.frame_start ? '0 : col_reg;
    assign row_eff  = byte_item.frame_start ? '0 : row_reg;
    assign base_eff = byte_item.frame_start ? '0 : base_reg;
    assign is_luma  = (p_eff < lsize_reg);
    assign p_inc    = p_eff + 1'b1;
    assign wrap     = (p_inc >= total_reg);

    // luma writes wait until the back end has drained all reads of the old frame
    assign byte_ready = (state_reg == RUN) && !back_status.q_full &&
                        (!is_luma || back_status.idle);
    assign accept     = byte_valid && byte_ready;

    assign ram_we    = accept && is_luma;
    assign ram_waddr = p_eff[ADDR_W-1:0];
    assign ram_wdata = byte_item.frame_byte;

    assign push                = accept && !is_luma && p_eff[0];
    assign push_job.col        = col_eff;
    assign push_job.row        = row_eff;
    assign push_job.u          = held_u_reg;
    assign push_job.v          = byte_item.frame_byte;
    assign push_job.frame_end  = wrap;
    assign push_base           = base_eff;
    assign frame_w             = w_reg;

    always_comb
    begin
        state_next      = state_reg;
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        lsize_next      = lsize_reg;
        total_next      = total_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        base_next       = base_reg;
        held_u_next     = held_u_reg;

        unique case (state_reg)
            SYNC_DIMS:
            begin
                w_next     = {w_clamp[COL_W-1:1], 1'b0};
                h_next     = {h_clamp[ROW_W-1:1], 1'b0};
                state_next = SYNC_SIZE;
            end
            SYNC_SIZE:
            begin
                lsize_next = POS_W'(area);
                state_next = SYNC_TOTAL;
            end
            SYNC_TOTAL:
            begin
                total_next = lsize_reg + (lsize_reg >> 1);
                state_next = SYNC_POS;
            end
            SYNC_POS:
            begin
                col_next  = '0;
                row_next  = '0;
                base_next = '0;
                if (pos_reg >= total_reg)
                begin
                    pos_next   = '0;
                    state_next = RUN;
                end
                else if (pos_reg < lsize_reg)
                begin
                    state_next = RUN;
                end
                else
                begin
                    rem_next   = {diff[POS_W-1:1], 1'b0};
                    state_next = SYNC_DIV;
                end
            end
            SYNC_DIV:
            begin
                // chroma offset -> block column/row, one pair row per cycle
                if (rem_reg >= POS_W'(w_reg))
                begin
                    rem_next  = rem_reg - POS_W'(w_reg);
                    row_next  = row_reg + ROW_W'(2);
                    base_next = base_reg + ADDR_W'({w_reg, 1'b0});
                end
                else
                begin
                    col_next   = rem_reg[COL_W-1:0];
                    base_next  = base_reg + ADDR_W'(rem_reg);
                    state_next = RUN;
                end
            end
            RUN:
            begin
                if (accept)
                begin
                    col_next  = col_eff;
                    row_next  = row_eff;
                    base_next = base_eff;
                    if (!is_luma && !p_eff[0])
                    begin
                        held_u_next = byte_item.frame_byte;
                    end
                    if (push)
                    begin
                        if (col_eff + COL_W'(2) == w_reg)
                        begin
                            col_next  = '0;
                            row_next  = row_eff + ROW_W'(2);
                            base_next = base_eff + ADDR_W'(2) + ADDR_W'(w_reg);
                        end
                        else
                        begin
                            col_next  = col_eff + COL_W'(2);
                            base_next = base_eff + ADDR_W'(2);
                        end
                    end
                    if (wrap)
                    begin
                        pos_next  = '0;
                        col_next  = '0;
                        row_next  = '0;
                        base_next = '0;
                    end
                    else
                    begin
                        pos_next = p_inc;
                    end
                end
            end
            default:
            begin
                state_next = SYNC_DIMS;
            end
        endcase

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_cfg_next  = cfg_data;
                CFG_FRAME_HEIGHT: height_cfg_next = cfg_data[ROW_W-1:0];
                default:          ;
            endcase
            state_next = SYNC_DIMS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SYNC_DIMS;
            width_cfg_reg  <= FRAME_WIDTH_RST;
            height_cfg_reg <= FRAME_HEIGHT_RST;
            w_reg          <= '0;
            h_reg          <= '0;
            lsize_reg      <= '0;
            total_reg      <= '0;
            pos_reg        <= '0;
            rem_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            base_reg       <= '0;
            held_u_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
            w_reg          <= w_next;
            h_reg          <= h_next;
            lsize_reg      <= lsize_next;
            total_reg      <= total_next;
            pos_reg        <= pos_next;
            rem_reg        <= rem_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            base_reg       <= base_next;
            held_u_reg     <= held_u_next;
        end
    end

endmodule

>>> rtl/core/y2argb_back.sv
`timescale 1ns / 1ps
// Back end: four luma reads per block job, color conversion, output register.
// Depends on y2argb_pkg; drives the read port of the luma RAM.
module y2argb_back #(
    parameter int ADDR_W = 19
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  y2argb_pkg::job_t              job,
    input  logic [ADDR_W-1:0]             job_base,
    output logic                          job_pop,
    input  logic [y2argb_pkg::COL_W-1:0]  frame_w,
    output logic                          ram_re,
    output logic [ADDR_W-1:0]             ram_raddr,
    input  logic [7:0]                    ram_rdata,
    output logic                          busy,
    output logic                          pix_valid,
    input  logic                          pix_ready,
    output y2argb_pkg::out_item_t         pix_item
);

    import y2argb_pkg::*;

    // block engine
    logic                 eng_valid_reg, eng_valid_next;
    job_t                 eng_job_reg;
    logic [ADDR_W-1:0]    eng_base_reg;
    logic [1:0]           k_reg, k_next;

    // read stage
    logic                      s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0]          s1_x_reg;
    logic [ROW_W-1:0]          s1_y_reg;
    logic signed [TERM_W-1:0]  s1_rt_reg;
    logic signed [TERM_W-1:0]  s1_g1t_reg;
    logic signed [PROD_W-1:0]  s1_g2p_reg;
    logic signed [TERM_W-1:0]  s1_bt_reg;
    logic                      s1_lob_reg;
    logic                      s1_lof_reg;

    // output register
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg;

    logic                      s1_adv;
    logic                      issue;
    logic                      eng_done;
    logic signed [8:0]         du;
    logic signed [8:0]         dv;
    logic signed [PROD_W-1:0]  prod_r;
    logic signed [PROD_W-1:0]  prod_g1;
    logic signed [PROD_W-1:0]  prod_g2;
    logic signed [PROD_W-1:0]  prod_b;
    logic signed [SUM_W-1:0]   y_s;
    logic signed [SUM_W-1:0]   r_s;
    logic signed [SUM_W-1:0]   a_s;
    logic signed [ACC_W-1:0]   gn_s;
    logic signed [SUM_W-1:0]   g_s;
    logic signed [SUM_W-1:0]   b_s;
    out_item_t                 pix_next;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || pix_ready);
    assign issue    = eng_valid_reg && (!s1_valid_reg || s1_adv);
    assign eng_done = issue && (k_reg == 2'd3);
    assign job_pop  = job_valid && (!eng_valid_reg || eng_done);
    assign busy     = eng_valid_reg;

    // k[0] selects the right column, k[1] the lower row
    assign ram_re    = issue;
    assign ram_raddr = eng_base_reg + (k_reg[1] ? ADDR_W'(frame_w) : ADDR_W'(0))
                       + ADDR_W'(k_reg[0]);

    assign du      = $signed({1'b0, eng_job_reg.u}) - CHROMA_BIAS;
    assign dv      = $signed({1'b0, eng_job_reg.v}) - CHROMA_BIAS;
    assign prod_r  = PROD_W'(COEF_R) * PROD_W'(dv);
    assign prod_g1 = PROD_W'(COEF_G1) * PROD_W'(dv);
    assign prod_g2 = PROD_W'(COEF_G2) * PROD_W'(du);
    assign prod_b  = PROD_W'(COEF_B) * PROD_W'(du);

    always_comb
    begin
        eng_valid_next = eng_valid_reg;
        k_next         = k_reg;
        if (job_pop)
        begin
            eng_valid_next = 1'b1;
            k_next         = 2'd0;
        end
        else if (issue)
        begin
            k_next = k_reg + 2'd1;
            if (eng_done)
            begin
                eng_valid_next = 1'b0;
            end
        end

        s1_valid_next = s1_valid_reg;
        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // color math on the registered luma byte
    assign y_s  = $signed({{(SUM_W-8){1'b0}}, ram_rdata});
    assign r_s  = y_s + SUM_W'(s1_rt_reg);
    assign a_s  = y_s - SUM_W'(s1_g1t_reg);
    assign gn_s = $signed({a_s, {Q_FRAC{1'b0}}}) - ACC_W'(s1_g2p_reg);
    assign g_s  = q14_trunc(gn_s);
    assign b_s  = y_s + SUM_W'(s1_bt_reg);

    assign pix_next.pixel_x       = s1_x_reg;
    assign pix_next.pixel_y       = s1_y_reg;
    assign pix_next.argb_pixel    = {ALPHA, clamp8(r_s), clamp8(g_s), clamp8(b_s)};
    assign pix_next.last_of_block = s1_lob_reg;
    assign pix_next.last_of_frame = s1_lof_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_valid_reg <= 1'b0;
            k_reg         <= 2'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            eng_valid_reg <= eng_valid_next;
            k_reg         <= k_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            eng_job_reg  <= job;
            eng_base_reg <= job_base;
        end
        if (issue)
        begin
            s1_x_reg   <= eng_job_reg.col + COL_W'(k_reg[0]);
            s1_y_reg   <= eng_job_reg.row + ROW_W'(k_reg[1]);
            s1_rt_reg  <= TERM_W'(q14_trunc(ACC_W'(prod_r)));
            s1_g1t_reg <= TERM_W'(q14_trunc(ACC_W'(prod_g1)));
            s1_g2p_reg <= prod_g2;
            s1_bt_reg  <= TERM_W'(q14_trunc(ACC_W'(prod_b)));
            s1_lob_reg <= (k_reg == 2'd3);
            s1_lof_reg <= (k_reg == 2'd3) && eng_job_reg.frame_end;
        end
        if (s1_adv)
        begin
            out_item_reg <= pix_next;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix_item  = out_item_reg;

endmodule

>>> rtl/core/yuv420sp_frame_to_argb.sv
`timescale 1ns / 1ps
// Top level: semi-planar 4:2:0 byte stream in, ARGB pixels of each 2x2 block out.
// Depends on y2argb_pkg, y2argb_front, y2argb_queue, y2argb_back, y2argb_ram.
//
//  channel   signals                           carries
//  byte      byte_valid/byte_ready/byte_item   one frame byte per transaction
//  pix       pix_valid/pix_ready/pix_item      one ARGB pixel per transaction
//  cfg       cfg_wr_en/cfg_index/cfg_data      register write, no handshake
//
// Luma bytes are written to the luma RAM and a U byte is held for its V byte. A V byte
// queues a block job; the back end reads the luma RAM once per pixel, and each result
// passes through the read stage and the output register.
// After reset or a register write the front end resizes in SYNC_DIMS, SYNC_SIZE,
// SYNC_TOTAL and SYNC_POS, and SYNC_DIV remaps a position inside the chroma plane.
// A luma byte is held off until all queued blocks have done their reads.
module yuv420sp_frame_to_argb #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [y2argb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [y2argb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               byte_valid,
    output logic                               byte_ready,
    input  y2argb_pkg::in_item_t               byte_item,
    output logic                               pix_valid,
    input  logic                               pix_ready,
    output y2argb_pkg::out_item_t              pix_item
);

    import y2argb_pkg::*;

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QUEUE_W = $bits(job_t) + ADDR_W;

    back_status_t        back_status;
    logic                push;
    job_t                push_job;
    logic [ADDR_W-1:0]   push_base;
    logic                pop;
    logic [QUEUE_W-1:0]  pop_data;
    logic                q_full;
    logic                q_empty;
    job_t                pop_job;
    logic [ADDR_W-1:0]   pop_base;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [7:0]          ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [7:0]          ram_rdata;
    logic [COL_W-1:0]    frame_w;
    logic                back_busy;

    assign back_status.q_full = q_full;
    assign back_status.idle   = q_empty && !back_busy;
    assign pop_job            = pop_data[QUEUE_W-1:ADDR_W];
    assign pop_base           = pop_data[ADDR_W-1:0];

    y2argb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_item   (byte_item),
        .back_status (back_status),
        .push        (push),
        .push_job    (push_job),
        .push_base   (push_base),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .frame_w     (frame_w)
    );

    y2argb_queue #(
        .WIDTH (QUEUE_W),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_job, push_base}),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    y2argb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_luma_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    y2argb_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (pop_job),
        .job_base  (pop_base),
        .job_pop   (pop),
        .frame_w   (frame_w),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .busy      (back_busy),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_item  (pix_item)
    );

endmodule
